>>> rtl/tpr_pkg.sv
// Package for the telemetry poll responder: frame constants, input codes and
// the controller state type. No dependencies.
package tpr_pkg;

	localparam int ENTRIES_DEF = 32;

	localparam logic [7:0] SYNC_BYTE   = 8'h7E;
	localparam logic [7:0] ESC_BYTE    = 8'h7D;
	localparam logic [7:0] ESC_SYNC    = 8'h5E;
	localparam logic [7:0] ESC_ESC     = 8'h5D;
	localparam logic [7:0] FRAME_TYPE  = 8'h10;
	localparam logic [7:0] DEV_ID_RST  = 8'hE4;
	localparam logic [7:0] TURN_RST    = 8'd6;

	typedef enum logic [1:0] {
		FUNC_RX    = 2'd0,
		FUNC_VALUE = 2'd1,
		FUNC_SETUP = 2'd2,
		FUNC_TICK  = 2'd3
	} func_t;

	localparam logic REG_DEVICE_ID = 1'b0;
	localparam logic REG_TURNAROUND = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_LOAD,
		ST_SEND
	} state_t;

	// One 8-bit end-around-carry accumulate step.
	function automatic logic [7:0] csum_add(input logic [7:0] c, input logic [7:0] b);
		logic [8:0] s;
		logic [9:0] t;
		begin
			s = {1'b0, c} + {1'b0, b};
			t = {1'b0, s} + {9'd0, s[8]};
			csum_add = t[7:0];
		end
	endfunction

endpackage

>>> rtl/tpr_table.sv
// Entry table memory for the telemetry poll responder: one synchronous
// memory, one write and one read port, read data registered. Uses tpr_pkg.
module tpr_table #(
	parameter int ENTRIES = tpr_pkg::ENTRIES_DEF,
	parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [96:0]   wdata,
	input  logic [IW-1:0] raddr,
	output logic [96:0]   rdata
);
	import tpr_pkg::*;

	// Word: fresh, due time[31:0], interval, field id, value.
	logic [96:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tpr_framer.sv
// Frame builder: turns one selected entry into stuffed frame bytes, one beat
// at a time, from its own frame registers. Uses tpr_pkg.
module tpr_framer #(
	parameter int IW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic [15:0]   fid,
	input  logic [31:0]   val,
	input  logic [IW-1:0] idx,
	output logic          busy,
	output logic          valid,
	input  logic          stall,
	output logic [7:0]    tx_byte,
	output logic          frame_end,
	output logic [4:0]    sent_index
);
	import tpr_pkg::*;

	logic [7:0] raw_q [8];
	logic [2:0] pos_q;
	logic       esc_q;
	logic       busy_q;
	logic [4:0] idx_q;
	logic [7:0] cs_q;
	logic [7:0] cur;
	logic       special;
	logic       last;
	logic       advance;

	assign cur = raw_q[pos_q];
	assign special = (cur == SYNC_BYTE) || (cur == ESC_BYTE);
	assign last = (pos_q == 3'd7) && (!special || esc_q);
	// A frame byte is finished when its last line beat is taken.
	assign advance = busy_q && !stall && !(special && !esc_q);

	// The checksum is accumulated one frame byte at a time as the bytes go
	// out; the checksum byte is filled in when byte six is finished.
	always_ff @(posedge clk) begin
		if (load) begin
			raw_q[0] <= FRAME_TYPE;
			raw_q[1] <= fid[7:0];
			raw_q[2] <= fid[15:8];
			raw_q[3] <= val[7:0];
			raw_q[4] <= val[15:8];
			raw_q[5] <= val[23:16];
			raw_q[6] <= val[31:24];
			idx_q    <= 5'(idx);
			cs_q     <= FRAME_TYPE;
		end else if (advance) begin
			if ((pos_q != 3'd0) && (pos_q != 3'd7)) begin
				cs_q <= csum_add(cs_q, cur);
			end
			if (pos_q == 3'd6) begin
				raw_q[7] <= 8'hFF - csum_add(cs_q, cur);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			esc_q  <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
			esc_q  <= 1'b0;
		end else if (busy_q && !stall) begin
			if (special && !esc_q) begin
				esc_q <= 1'b1;
			end else begin
				esc_q <= 1'b0;
				pos_q <= pos_q + 3'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign busy = busy_q;
	assign valid = busy_q;
	always_comb begin
		if (special && !esc_q) begin
			tx_byte = ESC_BYTE;
		end else if (special) begin
			tx_byte = (cur == SYNC_BYTE) ? ESC_SYNC : ESC_ESC;
		end else begin
			tx_byte = cur;
		end
	end
	assign frame_end = last;
	assign sent_index = idx_q;

endmodule

>>> rtl/telemetry_poll_responder.sv
// Telemetry poll responder top level: control sequencer over the entry table
// memory, plus the frame builder. Uses tpr_pkg, tpr_table and tpr_framer.
// Sequence: a value update reads its entry while idle and writes it back in
// ST_LOAD; setups, ticks and bytes that are no poll are done while idle. A poll
// scans the table one entry a cycle through the memory read port, then emits
// 8 to 15 beats, one a cycle while the output is not stalled.
// Throughput: one item at a time; a poll occupies the block until its last
// beat is taken. Reset is asynchronous; after it a clearing pass writes every
// table entry to zero, one a cycle, before items are accepted. Configuration
// writes are taken at any time.
module telemetry_poll_responder #(
	parameter int ENTRIES = tpr_pkg::ENTRIES_DEF,
	parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  rx_byte,
	input  logic [4:0]  entry_index,
	input  logic [31:0] entry_value,
	input  logic [15:0] entry_field_id,
	input  logic [15:0] entry_interval,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        frame_end,
	output logic [4:0]  sent_index
);
	import tpr_pkg::*;

	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
	localparam logic [IW:0] CNT_ALL = (IW+1)'(ENTRIES);

	// Configuration registers.
	logic [7:0] device_id_q;
	logic [7:0] turn_ticks_q;

	// Scalar state.
	logic [7:0]    prev_byte_q;
	logic [IW-1:0] last_idx_q;
	logic [31:0]   tick_q;
	logic [31:0]   turn_deadline_q;
	logic          turn_active_q;

	// Clearing pass after reset.
	logic          clr_q;
	logic [IW-1:0] clr_idx_q;

	// Sequencer.
	state_t        state_q, state_d;
	logic [IW-1:0] scan_idx_q;   // address being read
	logic [IW:0]   issued_q;     // reads issued so far
	logic          rd_pend_q;    // read data valid this cycle
	logic [IW-1:0] rd_idx_q;     // entry whose data is on rdata
	logic [IW:0]   checked_q;

	// Update item held for read-modify-write.
	logic [IW-1:0] op_idx_q;
	logic [31:0]   op_val_q;

	// Memory ports.
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [96:0]   mem_wdata;
	logic [IW-1:0] mem_raddr;
	logic [96:0]   mem_rdata;

	// Picked entry.
	logic [96:0]   pick_q;
	logic [IW-1:0] pick_idx_q;

	logic          accept;
	logic          idx_ok;
	logic          is_poll;
	logic          hit;
	logic          fr_busy;
	logic          fr_load;
	logic [IW-1:0] next_idx;

	assign in_stall = clr_q || (state_q != ST_IDLE) || fr_busy;
	assign accept = in_valid && !in_stall;
	assign idx_ok = ({2'b0, entry_index} < 7'(ENTRIES));
	assign is_poll = (func == FUNC_RX) && !turn_active_q && (prev_byte_q == SYNC_BYTE)
		&& (rx_byte == device_id_q);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
		begin
			wrap_inc = (i == LAST_IDX) ? '0 : i + IW'(1);
		end
	endfunction

	assign next_idx = wrap_inc(scan_idx_q);
	// An entry qualifies when fresh and its due time has been reached.
	assign hit = rd_pend_q && mem_rdata[96] && (tick_q >= mem_rdata[95:64]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q  <= DEV_ID_RST;
			turn_ticks_q <= TURN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEVICE_ID:  device_id_q  <= cfg_data;
				REG_TURNAROUND: turn_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= wrap_inc(clr_idx_q);
			if (clr_idx_q == LAST_IDX) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((func == FUNC_VALUE) && idx_ok) begin
						state_d = ST_LOAD;
					end else if (is_poll) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_PICK;
				end else if (checked_q == CNT_ALL) begin
					state_d = ST_IDLE;
				end
			end
			ST_PICK: state_d = ST_SEND;
			ST_LOAD: state_d = ST_IDLE;
			ST_SEND: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = op_idx_q;
		mem_wdata = '0;
		mem_raddr = scan_idx_q;
		fr_load   = 1'b0;
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					mem_raddr = IW'(entry_index);
					if (accept && (func == FUNC_SETUP) && idx_ok) begin
						mem_we    = 1'b1;
						mem_waddr = IW'(entry_index);
						mem_wdata = {1'b0, 32'd0, entry_interval, entry_field_id, 32'd0};
					end
				end
				ST_LOAD: begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, mem_rdata[95:32], op_val_q};
				end
				ST_PICK: begin
					mem_we    = 1'b1;
					mem_waddr = pick_idx_q;
					mem_wdata = {1'b0, tick_q + {16'd0, pick_q[63:48]}, pick_q[63:0]};
					fr_load   = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			prev_byte_q     <= '0;
			last_idx_q      <= '0;
			tick_q          <= '0;
			turn_deadline_q <= '0;
			turn_active_q   <= 1'b0;
			scan_idx_q      <= '0;
			issued_q        <= '0;
			checked_q       <= '0;
			rd_pend_q       <= 1'b0;
			rd_idx_q        <= '0;
		end else begin
			state_q <= state_d;
			rd_pend_q <= 1'b0;
			if (state_q == ST_IDLE && accept) begin
				unique case (func)
					FUNC_RX: begin
						if (!turn_active_q) begin
							prev_byte_q <= rx_byte;
						end
						scan_idx_q <= wrap_inc(last_idx_q);
						issued_q   <= '0;
						checked_q  <= '0;
					end
					FUNC_TICK: begin
						tick_q <= tick_q + 32'd1;
						if (turn_active_q && ((tick_q + 32'd1) > turn_deadline_q)) begin
							turn_active_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_SCAN) begin
				if (issued_q != CNT_ALL && !hit) begin
					rd_pend_q  <= 1'b1;
					rd_idx_q   <= scan_idx_q;
					scan_idx_q <= next_idx;
					issued_q   <= issued_q + (IW+1)'(1);
				end
				if (rd_pend_q) begin
					checked_q <= checked_q + (IW+1)'(1);
				end
			end
			if (state_q == ST_PICK) begin
				last_idx_q      <= pick_idx_q;
				turn_deadline_q <= tick_q + {24'd0, turn_ticks_q};
				turn_active_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			op_idx_q  <= IW'(entry_index);
			op_val_q  <= entry_value;
		end
		if (state_q == ST_SCAN && hit) begin
			pick_q     <= mem_rdata;
			pick_idx_q <= rd_idx_q;
		end
	end

	tpr_table #(.ENTRIES(ENTRIES), .IW(IW)) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tpr_framer #(.IW(IW)) u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fr_load),
		.fid        (pick_q[47:32]),
		.val        (pick_q[31:0]),
		.idx        (pick_idx_q),
		.busy       (fr_busy),
		.valid      (out_valid),
		.stall      (out_stall),
		.tx_byte    (tx_byte),
		.frame_end  (frame_end),
		.sent_index (sent_index)
	);

endmodule

>>> rtl/tpr_checker.sv
// Port-level checker for the telemetry poll responder, bound to the top
// level. Uses tpr_pkg for the stuffing bytes.
module tpr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] tx_byte,
	input logic       frame_end,
	input logic [4:0] sent_index
);
	import tpr_pkg::*;

	// No item is taken while a frame is still going out.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(in_valid && !in_stall))
		else $error("input accepted during frame");

	// The sync byte never appears on the line inside a frame.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> tx_byte != SYNC_BYTE)
		else $error("unstuffed sync byte");

	// The frame always opens with the frame type.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> tx_byte == FRAME_TYPE)
		else $error("frame does not start with type");

	// The entry index holds across a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !frame_end |=> out_valid && $stable(sent_index))
		else $error("index changed within frame");

endmodule

bind telemetry_poll_responder tpr_checker u_tpr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.tx_byte    (tx_byte),
	.frame_end  (frame_end),
	.sent_index (sent_index)
);

>>> test/telemetry_poll_responder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for telemetry_poll_responder: a directed table, then random
// polls, updates, setups and ticks, checked beat by beat against an in-bench predictor.
// Depends on tpr_pkg and the RTL top level only.
module telemetry_poll_responder_test;
	import tpr_pkg::*;

	localparam int NUM_ENTRIES = 32;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_end;
		logic [4:0] sent_index;
	} beat_t;

	typedef struct {
		func_t       fn;
		logic [7:0]  rx;
		logic [4:0]  idx;
		logic [31:0] val;
		logic [15:0] fid;
		logic [15:0] ivl;
		int          nbeats;   // -1: predictor only; otherwise the typed-in beat count
		logic [7:0]  first_byte;
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_DEVICE_ID;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = FUNC_TICK;
	logic [7:0] rx_byte = '0;
	logic [4:0] entry_index = '0;
	logic [31:0] entry_value = '0;
	logic [15:0] entry_field_id = '0;
	logic [15:0] entry_interval = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] tx_byte;
	logic frame_end;
	logic [4:0] sent_index;

	telemetry_poll_responder u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// The predictor's copy of the responder state.
	logic [31:0] p_value [NUM_ENTRIES];
	logic        p_fresh [NUM_ENTRIES];
	logic [31:0] p_due [NUM_ENTRIES];
	logic [15:0] p_interval [NUM_ENTRIES];
	logic [15:0] p_fid [NUM_ENTRIES];
	logic [7:0]  p_prev;
	logic [4:0]  p_last;
	logic [31:0] p_ticks;
	logic [31:0] p_turn_deadline;
	logic        p_turn_active;
	logic [7:0]  p_dev_id;
	logic [7:0]  p_turn_ticks;

	beat_t expected_beats[$];
	int errors = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	function automatic logic [7:0] eac_add(logic [7:0] c, logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, c} + {1'b0, b};
		s = {1'b0, s[7:0]} + s[8];
		return s[7:0];
	endfunction

	function automatic void push_stuffed(logic [7:0] b, ref logic [7:0] q[$]);
		if (b == SYNC_BYTE) begin
			q.push_back(ESC_BYTE);
			q.push_back(ESC_SYNC);
		end else if (b == ESC_BYTE) begin
			q.push_back(ESC_BYTE);
			q.push_back(ESC_ESC);
		end else begin
			q.push_back(b);
		end
	endfunction

	// Builds the stuffed frame of one entry and queues its beats.
	function automatic void queue_frame(logic [4:0] idx);
		logic [7:0] raw [8];
		logic [7:0] line[$];
		logic [7:0] c;
		beat_t b;
		raw[0] = FRAME_TYPE;
		raw[1] = p_fid[idx][7:0];
		raw[2] = p_fid[idx][15:8];
		for (int i = 0; i < 4; i++) raw[3 + i] = p_value[idx][8 * i +: 8];
		c = raw[0];
		for (int i = 1; i <= 6; i++) c = eac_add(c, raw[i]);
		raw[7] = 8'hFF - c;
		for (int i = 0; i < 8; i++) push_stuffed(raw[i], line);
		foreach (line[i]) begin
			b.tx_byte = line[i];
			b.frame_end = (i == line.size() - 1);
			b.sent_index = idx;
			expected_beats.push_back(b);
		end
	endfunction

	function automatic void predictor_reset();
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			p_value[i] = '0; p_fresh[i] = 1'b0; p_due[i] = '0;
			p_interval[i] = '0; p_fid[i] = '0;
		end
		p_prev = '0; p_last = '0; p_ticks = '0;
		p_turn_deadline = '0; p_turn_active = 1'b0;
		p_dev_id = DEV_ID_RST; p_turn_ticks = TURN_RST;
	endfunction

	// Advances the predictor by one item; returns the number of beats it queued.
	function automatic int predict_item(item_t it);
		int before_n;
		logic [4:0] idx;
		before_n = expected_beats.size();
		case (it.fn)
			FUNC_RX: begin
				if (!p_turn_active) begin
					if (p_prev == SYNC_BYTE && it.rx == p_dev_id) begin
						idx = p_last;
						for (int k = 0; k < NUM_ENTRIES; k++) begin
							idx = idx + 1'b1;
							if (p_fresh[idx] && p_ticks >= p_due[idx]) begin
								queue_frame(idx);
								p_last = idx;
								p_fresh[idx] = 1'b0;
								p_due[idx] = p_ticks + p_interval[idx];
								p_turn_deadline = p_ticks + p_turn_ticks;
								p_turn_active = 1'b1;
								break;
							end
						end
					end
					p_prev = it.rx;
				end
			end
			FUNC_VALUE: begin
				p_value[it.idx] = it.val;
				p_fresh[it.idx] = 1'b1;
			end
			FUNC_SETUP: begin
				p_fid[it.idx] = it.fid;
				p_interval[it.idx] = it.ivl;
				p_value[it.idx] = '0;
				p_fresh[it.idx] = 1'b0;
				p_due[it.idx] = '0;
			end
			default: begin
				p_ticks = p_ticks + 1;
				if (p_turn_active && p_ticks > p_turn_deadline) p_turn_active = 1'b0;
			end
		endcase
		return expected_beats.size() - before_n;
	endfunction

	// Output side: random stall and the beat-by-beat comparison.
	always @(posedge clk) begin
		beat_t exp_beat;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected beat tx_byte=%h", tx_byte);
				errors++;
			end else begin
				exp_beat = expected_beats.pop_front();
				if (tx_byte !== exp_beat.tx_byte) begin
					$error("tx_byte expected %h got %h", exp_beat.tx_byte, tx_byte);
					errors++;
				end
				if (frame_end !== exp_beat.frame_end) begin
					$error("frame_end expected %b got %b", exp_beat.frame_end, frame_end);
					errors++;
				end
				if (sent_index !== exp_beat.sent_index) begin
					$error("sent_index expected %0d got %0d", exp_beat.sent_index,
						sent_index);
					errors++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Drives one item and returns once the block has accepted it; valid stays up
	// so that the next item can follow without a gap.
	task automatic send_item(item_t it);
		int n;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= it.fn;
		rx_byte <= it.rx;
		entry_index <= it.idx;
		entry_value <= it.val;
		entry_field_id <= it.fid;
		entry_interval <= it.ivl;
		do @(posedge clk); while (in_stall);
		n = predict_item(it);
		if (it.nbeats >= 0) begin
			if (n != it.nbeats) begin
				$error("beat count expected %0d got %0d", it.nbeats, n);
				errors++;
			end else if (n > 0 && expected_beats[expected_beats.size() - n].tx_byte
					!== it.first_byte) begin
				$error("first tx_byte expected %h got %h", it.first_byte,
					expected_beats[expected_beats.size() - n].tx_byte);
				errors++;
			end
		end
	endtask

	// Waits for every queued beat, then for the poll scan latency, before a register write.
	task automatic drain_and_write(logic idx, logic [7:0] data);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (NUM_ENTRIES + 8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEVICE_ID) p_dev_id = data;
		else p_turn_ticks = data;
	endtask

	function automatic item_t mk(func_t fn, logic [7:0] rx, logic [4:0] idx,
			logic [31:0] val, logic [15:0] fid, logic [15:0] ivl, int nb,
			logic [7:0] fb);
		item_t it;
		it.fn = fn; it.rx = rx; it.idx = idx; it.val = val;
		it.fid = fid; it.ivl = ivl; it.nbeats = nb; it.first_byte = fb;
		return it;
	endfunction

	// Random item: well-formed poll sequences mixed with random updates, setups, ticks and bytes.
	task automatic random_item(logic [7:0] dev);
		int sel;
		logic [7:0] b;
		sel = $urandom_range(99);
		if (sel < 25) begin
			send_item(mk(FUNC_RX, SYNC_BYTE, '0, '0, '0, '0, -1, '0));
			send_item(mk(FUNC_RX, ($urandom_range(9) == 0) ? 8'($urandom) : dev,
				5'($urandom), $urandom, 16'($urandom), 16'($urandom), -1, '0));
		end else if (sel < 50) begin
			// Values with bytes that need stuffing show up often.
			b = ($urandom_range(1)) ? SYNC_BYTE : ESC_BYTE;
			send_item(mk(FUNC_VALUE, 8'($urandom), 5'($urandom),
				($urandom_range(1)) ? {b, 8'($urandom), b, 8'($urandom)} : $urandom,
				16'($urandom), 16'($urandom), -1, '0));
		end else if (sel < 58) begin
			send_item(mk(FUNC_SETUP, 8'($urandom), 5'($urandom), $urandom,
				($urandom_range(1)) ? 16'h7E7D : 16'($urandom),
				($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)),
				-1, '0));
		end else if (sel < 85) begin
			send_item(mk(FUNC_TICK, 8'($urandom), 5'($urandom), $urandom,
				16'($urandom), 16'($urandom), -1, '0));
		end else begin
			send_item(mk(FUNC_RX, 8'($urandom), 5'($urandom), $urandom,
				16'($urandom), 16'($urandom), -1, '0));
		end
	endtask

	initial begin
		item_t directed[$];
		logic [7:0] dev;
		int idle_phase [4];
		int stall_phase [4];
		idle_phase = '{0, 82, 0, 13};
		stall_phase = '{0, 0, 82, 13};
		predictor_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// After reset nothing is fresh, so a poll brings no frame.
		directed.push_back(mk(FUNC_RX, SYNC_BYTE, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(FUNC_RX, DEV_ID_RST, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(FUNC_SETUP, 0, 5'd31, 0, 16'hFFFF, 16'hFFFF, 0, 0));
		directed.push_back(mk(FUNC_VALUE, 0, 5'd31, 32'hFFFF_FFFF, 0, 0, 0, 0));
		directed.push_back(mk(FUNC_SETUP, 0, 5'd0, 0, 16'h0000, 16'h0000, 0, 0));
		directed.push_back(mk(FUNC_VALUE, 0, 5'd0, 32'h7E7D_7E7D, 0, 0, 0, 0));
		// Poll: round robin starts after entry 0, so entry 31 goes first.
		directed.push_back(mk(FUNC_RX, SYNC_BYTE, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(FUNC_RX, DEV_ID_RST, 0, 0, 0, 0, -1, FRAME_TYPE));
		// Bytes inside the turnaround window are dropped.
		directed.push_back(mk(FUNC_RX, SYNC_BYTE, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(FUNC_RX, DEV_ID_RST, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 7; i++) directed.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
		// Wrong id after sync: no reply.
		directed.push_back(mk(FUNC_RX, SYNC_BYTE, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(FUNC_RX, 8'h00, 0, 0, 0, 0, 0, 0));
		// Entry 0 carries stuffed value bytes.
		directed.push_back(mk(FUNC_RX, SYNC_BYTE, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(FUNC_RX, DEV_ID_RST, 0, 0, 0, 0, -1, FRAME_TYPE));
		foreach (directed[i]) send_item(directed[i]);

		// Random phases through several register settings, extremes included.
		for (int ph = 0; ph < 8; ph++) begin
			sender_idle_pct = idle_phase[ph % 4];
			receiver_stall_pct = stall_phase[ph % 4];
			case (ph)
				0: dev = DEV_ID_RST;
				1: dev = 8'hFF;
				2: dev = 8'h00;
				3: dev = SYNC_BYTE;
				default: dev = 8'($urandom);
			endcase
			drain_and_write(REG_DEVICE_ID, dev);
			drain_and_write(REG_TURNAROUND, (ph == 1) ? 8'hFF :
				(ph == 2) ? 8'h00 : 8'($urandom_range(8)));
			for (int i = 0; i < 44; i++) random_item(dev);
		end

		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (NUM_ENTRIES + 20) @(posedge clk);
		if (errors == 0) begin
			$display("telemetry_poll_responder_test OK");
		end else begin
			$display("telemetry_poll_responder_test NOT OK");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("telemetry_poll_responder_test NOT OK");
		$finish;
	end

endmodule
